// ===== design/mgmk_pkg.sv =====
package mgmk_pkg;

    localparam logic [1:0] OP_ASSOC  = 2'd0;
    localparam logic [1:0] OP_TEXT   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [2:0] CFG_KEY0  = 3'd0;
    localparam logic [2:0] CFG_KEY1  = 3'd1;
    localparam logic [2:0] CFG_KEY2  = 3'd2;
    localparam logic [2:0] CFG_KEY3  = 3'd3;
    localparam logic [2:0] CFG_NONH  = 3'd4;
    localparam logic [2:0] CFG_NONL  = 3'd5;
    localparam logic [2:0] CFG_DEC   = 3'd6;
    localparam logic [2:0] CFG_TAGB  = 3'd7;

    // datapath commands
    localparam logic [3:0] CMD_NOP     = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;  // latch item; key and nonce on a message's first item
    localparam logic [3:0] CMD_KS_INIT = 4'd2;  // a1/a0 from round keys 4i..4i+3
    localparam logic [3:0] CMD_KS_STEP = 4'd3;  // one Feistel step
    localparam logic [3:0] CMD_KS_SAVE = 4'd4;  // store four round keys
    localparam logic [3:0] CMD_C_START = 4'd5;  // cipher state := source
    localparam logic [3:0] CMD_C_ROUND = 4'd6;  // one LSX round
    localparam logic [3:0] CMD_C_DONE  = 4'd7;  // final key xor into dest
    localparam logic [3:0] CMD_M_START = 4'd8;  // multiplier start
    localparam logic [3:0] CMD_M_STEP  = 4'd9;  // eight multiplier bits
    localparam logic [3:0] CMD_M_DONE  = 4'd10; // accumulate product
    localparam logic [3:0] CMD_CLEAR   = 4'd11; // clear message state
    localparam logic [3:0] CMD_OUT     = 4'd12; // load output register

    // cipher source/destination
    localparam logic [2:0] CS_NONCE_Y = 3'd0;
    localparam logic [2:0] CS_NONCE_Z = 3'd1;
    localparam logic [2:0] CS_Z       = 3'd2;
    localparam logic [2:0] CS_Y       = 3'd3;
    localparam logic [2:0] CS_ACC     = 3'd4;

    // multiplier operand
    localparam logic [1:0] MB_DATA = 2'd0;
    localparam logic [1:0] MB_RES  = 2'd1;
    localparam logic [1:0] MB_LEN  = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] csel;
        logic [1:0] msel;
        logic [1:0] ks_i;
        logic [3:0] cnt;
        logic       out_tag;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       zero_len;
        logic       text_started;
        logic       in_message;
        logic       out_busy;
    } t_status;

    localparam logic [7:0] SBOX [256] = '{
        8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
        8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
        8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
        8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
        8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
        8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
        8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
        8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
        8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
        8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
        8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
        8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
        8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
        8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
        8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
        8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
        8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
        8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
        8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
        8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
        8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
        8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
        8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
        8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
        8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
        8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
        8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
        8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
        8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
        8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
        8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
        8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
    };

    localparam logic [7:0] LCOEF [16] = '{
        8'd148,8'd32,8'd133,8'd16,8'd194,8'd192,8'd1,8'd251,
        8'd1,8'd192,8'd194,8'd16,8'd133,8'd32,8'd148,8'd1
    };

    function automatic logic [7:0] gmul8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = 8'd0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
        end
        return r;
    endfunction

    // byte 0 at bits 127:120; one step of the LFSR-style linear layer
    function automatic logic [127:0] lin_step(input logic [127:0] v);
        logic [7:0] acc;
        acc = 8'd0;
        for (int i = 0; i < 16; i++)
            acc = acc ^ gmul8(v[127-8*i -: 8], LCOEF[i]);
        return {acc, v[127:8]};
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] v);
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            r[127-8*i -: 8] = SBOX[v[127-8*i -: 8]];
        return r;
    endfunction

    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
            m[127-8*i -: 8] = (5'(i) < n) ? 8'hFF : 8'h00;
        return m;
    endfunction

endpackage

// ===== design/mgmk_datapath.sv =====
module mgmk_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgmk_pkg::t_cmd      i_cmd,
    output mgmk_pkg::t_status   o_status,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic [1:0]          i_op,
    input  logic [63:0]         i_data_high,
    input  logic [63:0]         i_data_low,
    input  logic [4:0]          i_byte_count,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_out_kind,
    output logic [63:0]         o_out_data_high,
    output logic [63:0]         o_out_data_low,
    output logic [4:0]          o_out_byte_count
);
    import mgmk_pkg::*;

    logic [63:0]  r_key [4];
    logic [127:0] r_nonce, r_snonce;
    logic         r_dec;
    logic [4:0]   r_tagb;
    logic [63:0]  r_rk [20];
    logic [127:0] r_y, r_z, r_acc;
    logic [60:0]  r_atot, r_ttot;
    logic         r_inmsg, r_tstart;
    logic [1:0]   r_op;
    logic [4:0]   r_n;
    logic [127:0] r_d, r_res;
    logic [127:0] r_a1, r_a0, r_cst;
    logic [127:0] r_ma, r_mb, r_mc;
    logic         r_ov, r_ok;
    logic [127:0] r_od;
    logic [4:0]   r_on;

    logic [127:0] w_src, w_rk, w_c, w_t, w_ma, w_mb, w_mc, w_step, w_mask, w_tm;
    logic [4:0]   w_n, w_tb;
    logic [3:0]   w_ri;

    assign w_n  = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
    assign w_tb = (r_tagb > 5'd16) ? 5'd16 : r_tagb;
    assign w_mask = byte_mask(r_n);
    assign w_tm = byte_mask(w_tb);
    assign w_ri = i_cmd.cnt;
    assign w_rk = {r_rk[{w_ri, 1'b0}], r_rk[{w_ri, 1'b1}]};

    always_comb begin
        case (i_cmd.csel)
            CS_NONCE_Y: w_src = {1'b0, r_snonce[126:0]};
            CS_NONCE_Z: w_src = {1'b1, r_snonce[126:0]};
            CS_Z:       w_src = r_z;
            CS_Y:       w_src = r_y;
            default:    w_src = r_acc;
        endcase
    end

    // round constant for the key schedule, linear layer applied to 8i+j
    always_comb begin
        w_c[7:0] = {3'd0, i_cmd.ks_i, 3'd0} + {4'd0, i_cmd.cnt} + 8'd1;
        w_c[127:8] = '0;
        for (int k = 0; k < 16; k++)
            w_c = lin_step(w_c);
    end

    always_comb begin
        w_t = sub_bytes(r_a1 ^ w_c);
        for (int k = 0; k < 16; k++)
            w_t = lin_step(w_t);
        w_step = sub_bytes(r_cst ^ w_rk);
        for (int k = 0; k < 16; k++)
            w_step = lin_step(w_step);
    end

    always_comb begin
        w_ma = r_ma;
        w_mb = r_mb;
        w_mc = r_mc;
        for (int k = 0; k < 8; k++) begin
            if (w_mb[0]) w_mc = w_mc ^ w_ma;
            w_ma = {w_ma[126:0], 1'b0} ^ (w_ma[127] ? 128'h87 : 128'h0);
            w_mb = {1'b0, w_mb[127:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY0: r_key[0] <= i_cfg_data;
                CFG_KEY1: r_key[1] <= i_cfg_data;
                CFG_KEY2: r_key[2] <= i_cfg_data;
                CFG_KEY3: r_key[3] <= i_cfg_data;
                CFG_NONH: r_nonce[127:64] <= i_cfg_data;
                CFG_NONL: r_nonce[63:0] <= i_cfg_data;
                CFG_DEC:  r_dec <= i_cfg_data[0];
                CFG_TAGB: r_tagb <= i_cfg_data[4:0];
                default: ;
            endcase
        end
        case (i_cmd.op)
            CMD_LOAD: begin
                r_op <= i_op;
                r_n  <= w_n;
                r_d  <= {i_data_high, i_data_low} & byte_mask(w_n);
                if (!r_inmsg) begin
                    r_snonce <= r_nonce;
                    r_rk[0] <= r_key[0];
                    r_rk[1] <= r_key[1];
                    r_rk[2] <= r_key[2];
                    r_rk[3] <= r_key[3];
                end
            end
            CMD_KS_INIT: begin
                r_a1 <= {r_rk[{1'b0, i_cmd.ks_i, 2'd0}], r_rk[{1'b0, i_cmd.ks_i, 2'd1}]};
                r_a0 <= {r_rk[{1'b0, i_cmd.ks_i, 2'd2}], r_rk[{1'b0, i_cmd.ks_i, 2'd3}]};
            end
            CMD_KS_STEP: begin
                r_a1 <= w_t ^ r_a0;
                r_a0 <= r_a1;
            end
            CMD_KS_SAVE: begin
                r_rk[5'({i_cmd.ks_i, 2'd0}) + 5'd4] <= r_a1[127:64];
                r_rk[5'({i_cmd.ks_i, 2'd0}) + 5'd5] <= r_a1[63:0];
                r_rk[5'({i_cmd.ks_i, 2'd0}) + 5'd6] <= r_a0[127:64];
                r_rk[5'({i_cmd.ks_i, 2'd0}) + 5'd7] <= r_a0[63:0];
            end
            CMD_C_START: r_cst <= w_src;
            CMD_C_ROUND: r_cst <= w_step;
            CMD_C_DONE: begin
                case (i_cmd.csel)
                    CS_NONCE_Y: r_y <= r_cst ^ {r_rk[18], r_rk[19]};
                    CS_NONCE_Z: r_z <= r_cst ^ {r_rk[18], r_rk[19]};
                    CS_Z: begin
                        r_ma <= r_cst ^ {r_rk[18], r_rk[19]};
                        r_z[127:64] <= r_z[127:64] + 64'd1;
                    end
                    CS_Y: begin
                        r_res <= (r_d ^ r_cst ^ {r_rk[18], r_rk[19]}) & w_mask;
                        r_y[63:0] <= r_y[63:0] + 64'd1;
                    end
                    default: r_res <= (r_cst ^ {r_rk[18], r_rk[19]}) & w_tm;
                endcase
            end
            CMD_M_START: begin
                r_mc <= '0;
                case (i_cmd.msel)
                    MB_DATA: r_mb <= r_d;
                    MB_RES:  r_mb <= r_dec ? r_d : r_res;
                    default: r_mb <= {r_atot, 3'd0, r_ttot, 3'd0};
                endcase
            end
            CMD_M_STEP: begin
                r_ma <= w_ma;
                r_mb <= w_mb;
                r_mc <= w_mc;
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_dec <= 1'b0;
            r_tagb <= 5'd16;
            r_key[0] <= '0; r_key[1] <= '0; r_key[2] <= '0; r_key[3] <= '0;
            r_nonce <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == CMD_CLEAR) begin
            r_acc <= '0;
            r_atot <= '0;
            r_ttot <= '0;
            r_inmsg <= 1'b0;
            r_tstart <= 1'b0;
        end else begin
            case (i_cmd.op)
                CMD_LOAD: r_inmsg <= 1'b1;
                CMD_M_DONE: begin
                    r_acc <= r_acc ^ r_mc;
                    if (i_cmd.msel == MB_DATA) r_atot <= r_atot + 61'(r_n);
                    if (i_cmd.msel == MB_RES) begin
                        r_ttot <= r_ttot + 61'(r_n);
                        r_tstart <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == CMD_OUT) begin
            r_ov <= 1'b1;
            r_ok <= i_cmd.out_tag;
            r_od <= r_res;
            r_on <= i_cmd.out_tag ? w_tb : r_n;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    assign o_status.op = r_op;
    assign o_status.zero_len = (r_n == 5'd0);
    assign o_status.text_started = r_tstart;
    assign o_status.in_message = r_inmsg;
    assign o_status.out_busy = r_ov && i_stall;

    assign o_valid = r_ov;
    assign o_out_kind = r_ok;
    assign o_out_data_high = r_od[127:64];
    assign o_out_data_low = r_od[63:0];
    assign o_out_byte_count = r_on;
endmodule

// ===== design/mgmk_ctrl.sv =====
module mgmk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_op,
    output logic               o_stall,
    input  mgmk_pkg::t_status  i_status,
    output mgmk_pkg::t_cmd     o_cmd
);
    import mgmk_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KINIT = 4'd1;
    localparam logic [3:0] S_KSTEP = 4'd2;
    localparam logic [3:0] S_KSAVE = 4'd3;
    localparam logic [3:0] S_CSTRT = 4'd4;
    localparam logic [3:0] S_CRND  = 4'd5;
    localparam logic [3:0] S_CDONE = 4'd6;
    localparam logic [3:0] S_MSTRT = 4'd7;
    localparam logic [3:0] S_MSTEP = 4'd8;
    localparam logic [3:0] S_MDONE = 4'd9;
    localparam logic [3:0] S_DISP  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_CLEAR = 4'd12;

    // job codes that sequence one item
    localparam logic [2:0] J_Y   = 3'd0;
    localparam logic [2:0] J_Z   = 3'd1;
    localparam logic [2:0] J_H   = 3'd2;
    localparam logic [2:0] J_G   = 3'd3;
    localparam logic [2:0] J_TAG = 3'd4;

    logic [3:0] r_state, n_state;
    logic [2:0] r_job, n_job;
    logic [1:0] r_ki, n_ki;
    logic [3:0] r_cnt, n_cnt;
    logic [1:0] r_msel, n_msel;
    logic       w_acc;

    assign o_stall = (r_state != S_IDLE);
    assign w_acc = i_valid && (r_state == S_IDLE) && (i_op != OP_NONE);

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        n_ki = r_ki;
        n_cnt = r_cnt;
        n_msel = r_msel;
        o_cmd = '0;
        o_cmd.ks_i = r_ki;
        o_cmd.cnt = r_cnt;
        o_cmd.msel = r_msel;
        case (r_job)
            J_Y:     o_cmd.csel = CS_NONCE_Y;
            J_Z:     o_cmd.csel = CS_NONCE_Z;
            J_H:     o_cmd.csel = CS_Z;
            J_G:     o_cmd.csel = CS_Y;
            default: o_cmd.csel = CS_ACC;
        endcase
        case (r_state)
            S_IDLE: if (w_acc) begin
                o_cmd.op = CMD_LOAD;
                n_ki = 2'd0;
                n_cnt = 4'd0;
                n_job = J_Y;
                n_state = i_status.in_message ? S_DISP : S_KINIT;
            end
            S_KINIT: begin
                o_cmd.op = CMD_KS_INIT;
                n_cnt = 4'd0;
                n_state = S_KSTEP;
            end
            S_KSTEP: begin
                o_cmd.op = CMD_KS_STEP;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd7) n_state = S_KSAVE;
            end
            S_KSAVE: begin
                o_cmd.op = CMD_KS_SAVE;
                n_ki = r_ki + 2'd1;
                n_state = (r_ki == 2'd3) ? S_CSTRT : S_KINIT;
            end
            S_CSTRT: begin
                o_cmd.op = CMD_C_START;
                n_cnt = 4'd0;
                n_state = S_CRND;
            end
            S_CRND: begin
                o_cmd.op = CMD_C_ROUND;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) n_state = S_CDONE;
            end
            S_CDONE: begin
                o_cmd.op = CMD_C_DONE;
                case (r_job)
                    J_Y: begin n_job = J_Z; n_state = S_CSTRT; end
                    J_Z: n_state = S_DISP;
                    J_H: n_state = S_MSTRT;
                    J_G: begin n_job = J_H; n_msel = MB_RES; n_state = S_CSTRT; end
                    default: n_state = S_OUT;
                endcase
            end
            S_DISP: begin
                case (i_status.op)
                    OP_ASSOC: begin
                        n_job = J_H;
                        n_msel = MB_DATA;
                        n_state = (i_status.text_started || i_status.zero_len) ?
                                  S_IDLE : S_CSTRT;
                    end
                    OP_TEXT: begin
                        n_job = J_G;
                        n_state = i_status.zero_len ? S_IDLE : S_CSTRT;
                    end
                    default: begin
                        n_job = J_H;
                        n_msel = MB_LEN;
                        n_state = S_CSTRT;
                    end
                endcase
            end
            S_MSTRT: begin
                o_cmd.op = CMD_M_START;
                n_cnt = 4'd0;
                n_state = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.op = CMD_M_STEP;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) n_state = S_MDONE;
            end
            S_MDONE: begin
                o_cmd.op = CMD_M_DONE;
                if (r_msel == MB_LEN) begin
                    n_job = J_TAG;
                    n_state = S_CSTRT;
                end else begin
                    n_state = (r_msel == MB_RES) ? S_OUT : S_IDLE;
                end
            end
            S_OUT: if (!i_status.out_busy) begin
                o_cmd.op = CMD_OUT;
                o_cmd.out_tag = (r_job == J_TAG);
                n_state = (r_job == J_TAG) ? S_CLEAR : S_IDLE;
            end
            S_CLEAR: begin
                o_cmd.op = CMD_CLEAR;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job <= J_Y;
            r_ki <= 2'd0;
            r_cnt <= 4'd0;
            r_msel <= MB_DATA;
        end else begin
            r_state <= n_state;
            r_job <= n_job;
            r_ki <= n_ki;
            r_cnt <= n_cnt;
            r_msel <= n_msel;
        end
    end
endmodule

// ===== design/mgm_aead_kuznyechik_top.sv =====
// MGM authenticated encryption/decryption over the Kuznyechik cipher. One item is taken at a
// time. A message's first item also runs the key schedule (32 Feistel steps) and two cipher
// passes for the Y and Z counters. A cipher pass runs on the single round unit, the GF(2^128)
// multiply takes 8 bits per cycle. Text and finish items also wait while the output register
// is stalled. Key and nonce are sampled on a message's first item.
module mgm_aead_kuznyechik_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [63:0] o_out_data_high,
    output logic [63:0] o_out_data_low,
    output logic [4:0]  o_out_byte_count
);
    import mgmk_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mgmk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mgmk_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_data_high      (i_data_high),
        .i_data_low       (i_data_low),
        .i_byte_count     (i_byte_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_kind       (o_out_kind),
        .o_out_data_high  (o_out_data_high),
        .o_out_data_low   (o_out_data_low),
        .o_out_byte_count (o_out_byte_count)
    );
endmodule

// ===== verif/mgm_aead_kuznyechik_top_test.sv =====
`timescale 1ns / 100ps

module mgm_aead_kuznyechik_top_test;
    import mgmk_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  bc;
    } t_block;

    typedef struct {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  bc;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = CFG_KEY0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = OP_ASSOC;
    logic [63:0] i_data_high = '0;
    logic [63:0] i_data_low = '0;
    logic [4:0]  i_byte_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_out_kind;
    logic [63:0] o_out_data_high;
    logic [63:0] o_out_data_low;
    logic [4:0]  o_out_byte_count;

    mgm_aead_kuznyechik_top u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow configuration
    logic [63:0] key_sh [4];
    logic [63:0] nonce_hi_sh, nonce_lo_sh;
    logic        decrypt_sh;
    logic [4:0]  tag_len_sh;

    // mirrored message state
    logic [127:0] rkey [10];
    logic [127:0] acc_sum, z_ctr, y_ctr;
    logic [60:0]  assoc_total, text_total;
    logic         msg_open, text_seen;

    t_block  pending_blocks [$];
    t_result expected_results [$];
    int      mismatches = 0;
    bit      sender_quiet = 0, receiver_quiet = 0, long_hold_req = 0;

    const logic [7:0] PI_TBL [256] = '{
        252,238,221,17,207,110,49,22,251,196,250,218,35,197,4,77,
        233,119,240,219,147,46,153,186,23,54,241,187,20,205,95,193,
        249,24,101,90,226,92,239,33,129,28,60,66,139,1,142,79,
        5,132,2,174,227,106,143,160,6,11,237,152,127,212,211,31,
        235,52,44,81,234,200,72,171,242,42,104,162,253,58,206,204,
        181,112,14,86,8,12,118,18,191,114,19,71,156,183,93,135,
        21,161,150,41,16,123,154,199,243,145,120,111,157,158,178,177,
        50,117,25,61,255,53,138,126,109,84,198,128,195,189,13,87,
        223,245,36,169,62,168,67,201,215,121,214,246,124,34,185,3,
        224,15,236,222,122,148,176,188,220,232,40,80,78,51,10,74,
        167,151,96,115,30,0,98,68,26,184,56,130,100,159,38,65,
        173,69,70,146,39,94,85,47,140,163,165,125,105,213,149,59,
        7,88,179,64,134,172,29,247,48,55,107,228,136,217,231,137,
        225,27,131,73,76,63,248,254,141,83,170,144,202,216,133,97,
        32,113,103,164,45,43,9,91,203,155,37,208,190,229,108,82,
        89,166,116,210,230,244,180,192,209,102,175,194,57,75,99,182
    };
    const logic [7:0] L_COEF [16] = '{148,32,133,16,194,192,1,251,
                                      1,192,194,16,133,32,148,1};

    function automatic logic [7:0] field_mul8(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = a[7] ? ((a << 1) ^ 8'hC3) : (a << 1);
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_layer(logic [127:0] v);
        logic [7:0] s;
        for (int r = 0; r < 16; r++) begin
            s = 0;
            for (int i = 0; i < 16; i++) s ^= field_mul8(v[127-8*i -: 8], L_COEF[i]);
            v = {s, v[127:8]};
        end
        return v;
    endfunction

    function automatic logic [127:0] round_fn(logic [127:0] x, logic [127:0] k);
        logic [127:0] t;
        t = x ^ k;
        for (int i = 0; i < 16; i++) t[127-8*i -: 8] = PI_TBL[t[127-8*i -: 8]];
        return mix_layer(t);
    endfunction

    function automatic logic [127:0] encrypt_block(logic [127:0] x);
        for (int r = 0; r < 9; r++) x = round_fn(x, rkey[r]);
        return x ^ rkey[9];
    endfunction

    function automatic void schedule_keys();
        logic [127:0] a1, a0, t;
        rkey[0] = {key_sh[0], key_sh[1]};
        rkey[1] = {key_sh[2], key_sh[3]};
        for (int i = 0; i < 4; i++) begin
            a1 = rkey[2*i];
            a0 = rkey[2*i+1];
            for (int j = 1; j <= 8; j++) begin
                t = round_fn(a1, mix_layer(128'(8*i + j))) ^ a0;
                a0 = a1;
                a1 = t;
            end
            rkey[2*i+2] = a1;
            rkey[2*i+3] = a0;
        end
    endfunction

    function automatic logic [127:0] gf128_product(logic [127:0] a, logic [127:0] b);
        logic [127:0] c;
        logic         top;
        c = 0;
        for (int i = 0; i < 128; i++) begin
            top = a[127];
            if (b[0]) c ^= a;
            a = a << 1;
            if (top) a[7:0] ^= 8'h87;
            b = b >> 1;
        end
        return c;
    endfunction

    function automatic logic [127:0] lead_mask(int n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (i < n) ? 8'hFF : 8'h00;
        return m;
    endfunction

    function automatic void reset_message();
        acc_sum = 0; z_ctr = 0; y_ctr = 0;
        assoc_total = 0; text_total = 0;
        msg_open = 0; text_seen = 0;
    endfunction

    function automatic void auth_fold(logic [127:0] blk);
        logic [127:0] h;
        h = encrypt_block(z_ctr);
        z_ctr[127:64] = z_ctr[127:64] + 64'd1;
        acc_sum ^= gf128_product(h, blk);
    endfunction

    // advances the mirrored state; returns 1 and the result when one is due
    function automatic bit mgm_predict(t_block b, output t_result res);
        int           n, tb;
        logic [127:0] m, d, g, r, nb;
        if (b.op == OP_NONE) return 0;
        n = (b.bc > 16) ? 16 : b.bc;
        if (!msg_open) begin
            reset_message();
            schedule_keys();
            nb = {1'b0, nonce_hi_sh[62:0], nonce_lo_sh};
            y_ctr = encrypt_block(nb);
            nb[127] = 1'b1;
            z_ctr = encrypt_block(nb);
            msg_open = 1;
        end
        m = lead_mask(n);
        d = {b.hi, b.lo} & m;
        if (b.op == OP_ASSOC) begin
            if (text_seen || n == 0) return 0;
            auth_fold(d);
            assoc_total += 61'(n);
            return 0;
        end
        if (b.op == OP_TEXT) begin
            if (n == 0) return 0;
            text_seen = 1;
            g = encrypt_block(y_ctr);
            y_ctr[63:0] = y_ctr[63:0] + 64'd1;
            r = (d ^ g) & m;
            auth_fold(decrypt_sh ? d : r);
            text_total += 61'(n);
            res = '{1'b0, r[127:64], r[63:0], 5'(n)};
            return 1;
        end
        auth_fold({assoc_total, 3'b000, text_total, 3'b000});
        g = encrypt_block(acc_sum);
        tb = (tag_len_sh > 16) ? 16 : tag_len_sh;
        g &= lead_mask(tb);
        res = '{1'b1, g[127:64], g[63:0], 5'(tb)};
        reset_message();
        return 1;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s mismatch: got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // driver
    int sender_gap = 0;
    always @(posedge i_clk) begin
        t_block  nb;
        t_result res;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            if (mgm_predict('{i_op, i_data_high, i_data_low, i_byte_count}, res))
                expected_results.push_back(res);
            sender_gap = sender_quiet ? 0 : $urandom_range(0, 8);
            if (sender_gap == 0 && pending_blocks.size() > 0) begin
                nb = pending_blocks.pop_front();
                i_op <= nb.op; i_data_high <= nb.hi; i_data_low <= nb.lo;
                i_byte_count <= nb.bc;
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (sender_gap > 0) begin
                sender_gap--;
            end else if (pending_blocks.size() > 0) begin
                nb = pending_blocks.pop_front();
                i_op <= nb.op; i_data_high <= nb.hi; i_data_low <= nb.lo;
                i_byte_count <= nb.bc;
                i_valid <= 1'b1;
            end
        end
    end

    // receiver stall
    int stall_left = 0, hold_count = 0;
    always @(posedge i_clk) begin
        if (!long_hold_req) hold_count = 0;
        if (long_hold_req && hold_count < 600) begin
            hold_count++;
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall)
                stall_left = receiver_quiet ? 0 : $urandom_range(0, 8);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_data_high, 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_kind !== want.kind)
                    report_mismatch("kind", 64'(o_out_kind), 64'(want.kind));
                if (o_out_data_high !== want.hi)
                    report_mismatch("data_high", o_out_data_high, want.hi);
                if (o_out_data_low !== want.lo)
                    report_mismatch("data_low", o_out_data_low, want.lo);
                if (o_out_byte_count !== want.bc)
                    report_mismatch("byte_count", 64'(o_out_byte_count), 64'(want.bc));
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        case (idx)
            CFG_NONH: nonce_hi_sh = val;
            CFG_NONL: nonce_lo_sh = val;
            CFG_DEC:  decrypt_sh = val[0];
            CFG_TAGB: tag_len_sh = val[4:0];
            default:  key_sh[idx[1:0]] = val;
        endcase
    endtask

    task automatic cfg_all(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                           logic [63:0] k3, logic [63:0] nh, logic [63:0] nl,
                           logic dec, logic [4:0] tb);
        cfg_write(CFG_KEY0, k0); cfg_write(CFG_KEY1, k1);
        cfg_write(CFG_KEY2, k2); cfg_write(CFG_KEY3, k3);
        cfg_write(CFG_NONH, nh); cfg_write(CFG_NONL, nl);
        cfg_write(CFG_DEC, {63'd0, dec}); cfg_write(CFG_TAGB, {59'd0, tb});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void push_block(logic [1:0] op, logic [4:0] bc);
        pending_blocks.push_back('{op, rand64(), rand64(), bc});
    endfunction

    function automatic logic [4:0] last_len();
        return ($urandom_range(0, 2) == 0) ? 5'($urandom_range(1, 15)) : 5'd16;
    endfunction

    function automatic void push_noise();
        case ($urandom_range(0, 4))
            0: push_block(OP_NONE, 5'($urandom));
            1: push_block(2'($urandom_range(0, 1)), 5'd0);
            2: push_block(2'($urandom_range(0, 1)), 5'($urandom_range(17, 31)));
            3: push_block(2'($urandom_range(0, 1)), 5'($urandom_range(1, 15)));
            default: push_block(OP_ASSOC, 5'd16);
        endcase
    endfunction

    function automatic int push_message();
        int na, nt, cnt;
        na = $urandom_range(0, 3);
        nt = $urandom_range(0, 4);
        cnt = 0;
        for (int i = 0; i < na; i++) begin
            push_block(OP_ASSOC, (i == na - 1) ? last_len() : 5'd16);
            cnt++;
        end
        for (int i = 0; i < nt; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_noise();
                cnt++;
            end
            push_block(OP_TEXT, (i == nt - 1) ? last_len() : 5'd16);
            cnt++;
        end
        push_block(OP_FINISH, 5'($urandom));
        return cnt + 1;
    endfunction

    task automatic drain();
        wait (pending_blocks.size() == 0 && !i_valid && expected_results.size() == 0);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        int sent;
        reset_message();
        key_sh = '{default: '0};
        nonce_hi_sh = 0; nonce_lo_sh = 0; decrypt_sh = 0; tag_len_sh = 5'd16;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, then extremes
        push_block(OP_NONE, 5'd16);
        pending_blocks.push_back('{OP_ASSOC, '1, '1, 5'd16});
        pending_blocks.push_back('{OP_ASSOC, '1, '1, 5'd5});
        pending_blocks.push_back('{OP_ASSOC, '1, '1, 5'd0});
        pending_blocks.push_back('{OP_TEXT, '0, '0, 5'd16});
        pending_blocks.push_back('{OP_TEXT, '1, '1, 5'd31});
        pending_blocks.push_back('{OP_ASSOC, '1, '1, 5'd16});
        pending_blocks.push_back('{OP_TEXT, '1, '1, 5'd1});
        pending_blocks.push_back('{OP_TEXT, '1, '1, 5'd0});
        pending_blocks.push_back('{OP_TEXT, '1, '1, 5'd9});
        pending_blocks.push_back('{OP_FINISH, '0, '0, 5'd0});
        pending_blocks.push_back('{OP_FINISH, '1, '1, 5'd31});
        drain();
        cfg_all('1, '1, '1, '1, '1, '1, 1'b1, 5'd0);
        pending_blocks.push_back('{OP_ASSOC, '1, '1, 5'd8});
        pending_blocks.push_back('{OP_TEXT, '1, '1, 5'd15});
        pending_blocks.push_back('{OP_FINISH, '0, '0, 5'd16});
        drain();
        cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(), 1'b0, 5'd31);
        pending_blocks.push_back('{OP_TEXT, '1, '0, 5'd16});
        pending_blocks.push_back('{OP_TEXT, '0, '1, 5'd7});
        pending_blocks.push_back('{OP_FINISH, '0, '0, 5'd16});
        drain();

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            cfg_all(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                    1'($urandom), (ph == 2) ? 5'd1 : (ph == 3) ? 5'd16 : 5'($urandom));
            sender_quiet = (ph == 4);
            receiver_quiet = (ph == 4 || ph == 6);
            long_hold_req = (ph == 5);
            sent = 0;
            while (sent < 190) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_noise();
                    sent++;
                end else begin
                    sent += push_message();
                end
            end
            drain();
            long_hold_req = 0;
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
